### hdl/hhc_pkg.sv
// ----------------------------------------------------------------------------
// hhc_pkg
// Shared types, codes and byte classes for the header field check.
// ----------------------------------------------------------------------------
package hhc_pkg;

   localparam logic [1:0] KIND_NAME  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_EMPTY_NAME = 2'd1;
   localparam logic [1:0] ERR_NAME_BYTE  = 2'd2;
   localparam logic [1:0] ERR_VALUE_BYTE = 2'd3;

   localparam logic [1:0] PH_NORMAL  = 2'd0;
   localparam logic [1:0] PH_CR      = 2'd1;
   localparam logic [1:0] PH_CRLF    = 2'd2;
   localparam logic [1:0] PH_FOLDING = 2'd3;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_HT = 8'h09;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       name_ok;
      logic       content;
      logic       blank;
      logic       cr;
      logic       lf;
   } qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic is_vchar_obs(input logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h7E) || c >= 8'h80;
   endfunction

   function automatic logic is_tchar(input logic [7:0] c);
      logic alnum;
      alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      return alnum || c == "!" || c == "#" || c == "$" || c == "%" || c == "&"
         || c == 8'h27 || c == "*" || c == "+" || c == "-" || c == "." || c == "^"
         || c == "_" || c == 8'h60 || c == "|" || c == "~";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SP || c == CH_HT;
   endfunction

endpackage

### hdl/hhc_front.sv
// ----------------------------------------------------------------------------
// hhc_front
// Accepts input items and classifies the byte before it enters the queue.
// ----------------------------------------------------------------------------
module hhc_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_item_kind,
   input  logic [7:0]        req_data_byte,
   input  logic              strict_names,
   input  hhc_pkg::qstat_type q_stat,
   output logic              push,
   output hhc_pkg::qent_type push_ent
);
   import hhc_pkg::*;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      push_ent.kind    = req_item_kind;
      push_ent.data    = req_data_byte;
      push_ent.name_ok = strict_names ? is_tchar(req_data_byte)
                                      : is_vchar_obs(req_data_byte);
      push_ent.content = is_vchar_obs(req_data_byte) || is_blank(req_data_byte);
      push_ent.blank   = is_blank(req_data_byte);
      push_ent.cr      = (req_data_byte == CH_CR);
      push_ent.lf      = (req_data_byte == CH_LF);
   end

endmodule

### hdl/hhc_queue.sv
// ----------------------------------------------------------------------------
// hhc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hhc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hhc_pkg::qent_type  push_ent,
   input  logic               pop,
   output hhc_pkg::qent_type  head_ent,
   output hhc_pkg::qstat_type q_stat
);
   import hhc_pkg::*;

   qent_type            ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_ent     = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

### hdl/hhc_back.sv
// ----------------------------------------------------------------------------
// hhc_back
// Runs the header state (fold phase, name seen, held error) on queued items
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module hhc_back (
   input  logic               clock,
   input  logic               reset,
   input  hhc_pkg::qent_type  head_ent,
   input  hhc_pkg::qstat_type q_stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_header_done,
   output logic [1:0]         rsp_error_code
);
   import hhc_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic       seen_ff, seen_in;
   logic [1:0] err_ff, err_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       bvalid_ff;
   logic       done_ff;
   logic [1:0] code_ff;

   logic       out_free;
   logic       emit, done;
   logic [7:0] ob;
   logic [1:0] code;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = out_free && !q_stat.empty;

   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;
      emit     = 1'b0;
      done     = 1'b0;
      ob       = head_ent.data;
      code     = ERR_NONE;
      if (head_ent.kind == KIND_END) begin
         done = 1'b1;
         code = err_ff;
         if (code == ERR_NONE && !seen_ff) begin
            code = ERR_EMPTY_NAME;
         end
         if (code == ERR_NONE && (phase_ff == PH_CR || phase_ff == PH_CRLF)) begin
            code = ERR_VALUE_BYTE;
         end
         phase_in = PH_NORMAL;
         seen_in  = 1'b0;
         err_in   = ERR_NONE;
      end else if (head_ent.kind == KIND_NAME && err_ff == ERR_NONE) begin
         seen_in = 1'b1;
         if (!head_ent.name_ok) begin
            err_in = ERR_NAME_BYTE;
         end
      end else if (head_ent.kind == KIND_VALUE && err_ff == ERR_NONE) begin
         if (!seen_ff) begin
            err_in = ERR_EMPTY_NAME;
         end else begin
            case (phase_ff)
               PH_CR: begin
                  if (head_ent.lf) begin
                     phase_in = PH_CRLF;
                  end else begin
                     err_in = ERR_VALUE_BYTE;
                  end
               end
               PH_CRLF: begin
                  if (head_ent.blank) begin
                     phase_in = PH_FOLDING;
                     emit     = 1'b1;
                     ob       = CH_SP;
                  end else begin
                     err_in = ERR_VALUE_BYTE;
                  end
               end
               default: begin
                  // Inside a fold, spaces and tabs are dropped silently.
                  if (!(phase_ff == PH_FOLDING && head_ent.blank)) begin
                     if (head_ent.cr) begin
                        phase_in = PH_CR;
                     end else if (head_ent.content) begin
                        phase_in = PH_NORMAL;
                        emit     = 1'b1;
                     end else begin
                        err_in = ERR_VALUE_BYTE;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         seen_ff  <= 1'b0;
         err_ff   <= ERR_NONE;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            seen_ff  <= seen_in;
            err_ff   <= err_in;
         end
         if (out_free) begin
            valid_ff <= pop && (emit || done);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         byte_ff   <= emit ? ob : 8'd0;
         bvalid_ff <= emit;
         done_ff   <= done;
         code_ff   <= code;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_header_done = done_ff;
   assign rsp_error_code  = code_ff;

endmodule

### hdl/http_header_check_unfold.sv
// ----------------------------------------------------------------------------
// http_header_check_unfold
// Checks one streamed header field and rewrites obsolete line folds.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle for as long as neither side stalls.
// The front classifies the byte and writes it into a four-entry queue, and
// the back updates the fold and error state and loads the result register.
// The queue lets the input keep flowing for four items while the output is
// stalled. Name, value and end items are taken alike; only value bytes that
// survive the check and the end marker produce results. The strict_names
// register is written through the csr_ port, which is always ready; write it
// only while no item is in flight.
module http_header_check_unfold (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_item_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_header_done,
   output logic [1:0] rsp_error_code,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);
   import hhc_pkg::*;

   logic      strict_ff;
   logic      push, pop;
   qent_type  push_ent, head_ent;
   qstat_type q_stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         strict_ff <= csr_data;
      end
   end

   hhc_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item_kind (req_item_kind),
      .req_data_byte (req_data_byte),
      .strict_names  (strict_ff),
      .q_stat        (q_stat),
      .push          (push),
      .push_ent      (push_ent)
   );

   hhc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .head_ent (head_ent),
      .q_stat   (q_stat)
   );

   hhc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_ent        (head_ent),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_header_done (rsp_header_done),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

### hdl/hhc_checker.sv
// ----------------------------------------------------------------------------
// hhc_checker
// Port-level checks on the results of the header field check.
// ----------------------------------------------------------------------------
module hhc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_header_done,
   input logic [1:0] rsp_error_code
);
   import hhc_pkg::*;

   // A result that is held back stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Every result is either a value byte or a verdict, never both or neither.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_valid != rsp_header_done))
      else $error("result is not exactly one of byte or verdict");

   // Value bytes carry no error code.
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_error_code == ERR_NONE)
      else $error("value byte with error code");

   // A verdict carries a zero byte.
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |-> rsp_out_byte == 8'd0)
      else $error("verdict with nonzero byte");

endmodule

bind http_header_check_unfold hhc_checker u_hhc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_header_done (rsp_header_done),
   .rsp_error_code  (rsp_error_code)
);
